// File: rtl/mipmap_box_downsampler_assert.svh
// Assertion macros shared by the mipmap box downsampler RTL.
`ifndef MIPMAP_BOX_DOWNSAMPLER_ASSERT_SVH
`define MIPMAP_BOX_DOWNSAMPLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MBD_ASSERT_NOW(label, clock, reset, cond, conseq) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define MBD_ASSERT_NEXT(label, clock, reset, cond, conseq) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
    else $error("%m: next-cycle check failed");

`endif

// File: rtl/mbd_pkg.sv
// Package with register indexes, reset values and the channel averaging function.
`default_nettype none

package mbd_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_RED_MASK    = 3'd0;
  localparam logic [2:0] REG_GREEN_MASK  = 3'd1;
  localparam logic [2:0] REG_BLUE_MASK   = 3'd2;
  localparam logic [2:0] REG_ALPHA_MASK  = 3'd3;
  localparam logic [2:0] REG_WIDE_PIXELS = 3'd4;
  localparam logic [2:0] REG_DEST_WIDTH  = 3'd5;

  // Register values after reset.
  localparam logic [31:0] RED_MASK_RESET    = 32'h00FF_0000;
  localparam logic [31:0] GREEN_MASK_RESET  = 32'h0000_FF00;
  localparam logic [31:0] BLUE_MASK_RESET   = 32'h0000_00FF;
  localparam logic [31:0] ALPHA_MASK_RESET  = 32'hFF00_0000;
  localparam logic [10:0] DEST_WIDTH_RESET  = 11'd1;

  typedef logic [31:0] pixel_t;

  // Average of one channel over a 2x2 block. The masked values are summed in place;
  // the mask has no bits below its lowest set bit, so dividing the sum by four and
  // masking gives the same result as shifting down, dividing and shifting back.
  function automatic pixel_t box_channel(input pixel_t p0, input pixel_t p1,
                                         input pixel_t p2, input pixel_t p3,
                                         input pixel_t mask);
    logic [33:0] total;
    total = {2'b00, p0 & mask} + {2'b00, p1 & mask}
          + {2'b00, p2 & mask} + {2'b00, p3 & mask};
    return total[33:2] & mask;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mbd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module mbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/mipmap_box_downsampler.sv
// Top level of the 2x2 box-filter mipmap downsampler.
// Source pixels are taken in raster order, in rows of 2*W pixels, where W is dest_width
// clamped to the range 1 to MAX_SOURCE_WIDTH/2. Pixels of even rows are written into
// two line RAMs, one for even and one for odd columns, so that an odd-column pixel of
// an odd row reads both upper neighbours in one access at the pair address. The output
// register lets the next source pixel be taken while a result waits. Each RAM has one
// write and one read port and a row never reads and writes them at once, so the
// sustained rate is one source pixel per clock while dst_stall is low. Per channel the
// four masked values are summed, divided by four with truncation and masked again.
// Configuration must be written only while the block is idle; this is not enforced.
`default_nettype none
`include "mipmap_box_downsampler_assert.svh"

module mipmap_box_downsampler
  import mbd_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // Source pixel channel
  input  wire logic        src_valid,
  output logic             src_stall,
  input  wire logic [31:0] source_pixel,
  // Destination pixel channel
  output logic             dst_valid,
  input  wire logic        dst_stall,
  output logic [31:0]      dest_pixel,
  output logic             row_end
);

  localparam int HALF_WIDTH = MAX_SOURCE_WIDTH / 2;
  localparam int CW = $clog2(MAX_SOURCE_WIDTH);
  localparam int AW = (HALF_WIDTH > 1) ? $clog2(HALF_WIDTH) : 1;

  // Configuration registers
  pixel_t      red_mask;
  pixel_t      green_mask;
  pixel_t      blue_mask;
  pixel_t      alpha_mask;
  logic        wide_pixels;
  logic [10:0] dest_width;

  // Stream position and held pixel
  logic [CW-1:0] column;
  logic          odd_row;
  pixel_t        held_left_pixel;

  // Stage one: waiting for line RAM data
  logic   s1_valid;
  logic   s1_end;
  pixel_t s1_left;
  pixel_t s1_right;

  // Input stage signals
  logic [12:0]   width_eff;
  logic [CW-1:0] last_col;
  logic          row_last;
  pixel_t        pixel_in;
  logic          src_accept;
  logic          out_advance;
  logic [AW-1:0] pair_addr;
  logic          wr_even;
  logic          wr_odd;
  logic          rd_pair;
  pixel_t        upper_left_raw;
  pixel_t        upper_right_raw;
  pixel_t        upper_left;
  pixel_t        upper_right;
  pixel_t        block_avg;

  assign cfg_ready = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      red_mask    <= RED_MASK_RESET;
      green_mask  <= GREEN_MASK_RESET;
      blue_mask   <= BLUE_MASK_RESET;
      alpha_mask  <= ALPHA_MASK_RESET;
      wide_pixels <= 1'b1;
      dest_width  <= DEST_WIDTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RED_MASK:    red_mask    <= cfg_data;
        REG_GREEN_MASK:  green_mask  <= cfg_data;
        REG_BLUE_MASK:   blue_mask   <= cfg_data;
        REG_ALPHA_MASK:  alpha_mask  <= cfg_data;
        REG_WIDE_PIXELS: wide_pixels <= cfg_data[0];
        REG_DEST_WIDTH:  dest_width  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Effective width and the last source column of a row.
  always_comb begin
    width_eff = {2'b00, dest_width};
    if (dest_width == 11'd0) begin
      width_eff = 13'd1;
    end else if (width_eff > 13'(HALF_WIDTH)) begin
      width_eff = 13'(HALF_WIDTH);
    end
  end

  assign last_col = CW'({width_eff, 1'b0} - 14'd1);
  assign row_last = (column >= last_col);
  assign pixel_in = wide_pixels ? source_pixel : {16'h0000, source_pixel[15:0]};

  // Handshake: the output register frees stage one, which frees the input.
  assign out_advance = !dst_valid || !dst_stall;
  assign src_stall   = s1_valid && !out_advance;
  assign src_accept  = src_valid && !src_stall;

  // Line RAM access: even rows write, odd columns of odd rows read a column pair.
  assign pair_addr = AW'(column >> 1);
  assign wr_even   = src_accept && !odd_row && !column[0];
  assign wr_odd    = src_accept && !odd_row && column[0];
  assign rd_pair   = src_accept && odd_row && column[0];

  mbd_ram #(
    .WIDTH (32),
    .DEPTH (HALF_WIDTH)
  ) u_even_col_ram (
    .clk     (clk),
    .wr_en   (wr_even),
    .wr_addr (pair_addr),
    .wr_data (pixel_in),
    .rd_en   (rd_pair),
    .rd_addr (pair_addr),
    .rd_data (upper_left_raw)
  );

  mbd_ram #(
    .WIDTH (32),
    .DEPTH (HALF_WIDTH)
  ) u_odd_col_ram (
    .clk     (clk),
    .wr_en   (wr_odd),
    .wr_addr (pair_addr),
    .wr_data (pixel_in),
    .rd_en   (rd_pair),
    .rd_addr (pair_addr),
    .rd_data (upper_right_raw)
  );

  // Stream position, held left pixel and stage one.
  always_ff @(posedge clk) begin
    if (rst) begin
      column          <= '0;
      odd_row         <= 1'b0;
      held_left_pixel <= '0;
      s1_valid        <= 1'b0;
    end else begin
      if (src_accept) begin
        if (row_last) begin
          column  <= '0;
          odd_row <= !odd_row;
        end else begin
          column <= column + 1'b1;
        end
        if (odd_row && !column[0]) begin
          held_left_pixel <= pixel_in;
        end
        s1_valid <= rd_pair;
      end else if (out_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pair) begin
      s1_end   <= row_last;
      s1_left  <= held_left_pixel;
      s1_right <= pixel_in;
    end
  end

  // Averaging of the 2x2 block once the upper pixels are back from the RAMs.
  always_comb begin
    upper_left  = wide_pixels ? upper_left_raw  : {16'h0000, upper_left_raw[15:0]};
    upper_right = wide_pixels ? upper_right_raw : {16'h0000, upper_right_raw[15:0]};
    block_avg = box_channel(upper_left, upper_right, s1_left, s1_right, red_mask)
              | box_channel(upper_left, upper_right, s1_left, s1_right, green_mask)
              | box_channel(upper_left, upper_right, s1_left, s1_right, blue_mask)
              | box_channel(upper_left, upper_right, s1_left, s1_right, alpha_mask);
    if (!wide_pixels) begin
      block_avg = {16'h0000, block_avg[15:0]};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (out_advance) begin
      dst_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && s1_valid) begin
      dest_pixel <= block_avg;
      row_end    <= s1_end;
    end
  end

  // Checks on the line RAM use and the pipeline.
  `MBD_ASSERT_NOW(a_no_read_write_overlap, clk, rst, (wr_even || wr_odd), !rd_pair)
  `MBD_ASSERT_NEXT(a_stage_one_holds, clk, rst, (s1_valid && !out_advance), s1_valid)
  `MBD_ASSERT_NEXT(a_row_wraps, clk, rst, (src_accept && row_last),
                   (column == '0) && (odd_row != $past(odd_row)))
  `MBD_ASSERT_NEXT(a_result_reaches_output, clk, rst, (s1_valid && out_advance), dst_valid)

endmodule

`default_nettype wire
